// File: hdl/rdcc_pkg.sv
// shared constants and types of the register dma copy card
`timescale 1ns / 1ps
package rdcc_pkg;

  // default number of word moves per bus cycle
  localparam int WPC_DEFAULT = 4;

  localparam logic [31:0] CARD_ID     = 32'h0B5C_0001;
  localparam logic [31:0] NONE_DRIVEN = 32'hFFFF_FFFF;

  // request function codes
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_RUN   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_MOVE  = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  // register indexes (byte offset >> 2)
  localparam int REG_IDX_W = 6;
  localparam logic [REG_IDX_W-1:0] REG_ID      = 6'd0;
  localparam logic [REG_IDX_W-1:0] REG_CTRL    = 6'd1;
  localparam logic [REG_IDX_W-1:0] REG_STATUS  = 6'd2;
  localparam logic [REG_IDX_W-1:0] REG_SRC     = 6'd3;
  localparam logic [REG_IDX_W-1:0] REG_DST     = 6'd4;
  localparam logic [REG_IDX_W-1:0] REG_LEN     = 6'd5;
  localparam logic [REG_IDX_W-1:0] REG_SCRATCH = 6'd6;
  localparam logic [REG_IDX_W-1:0] REG_RUNS    = 6'd7;
  localparam logic [REG_IDX_W-1:0] REG_COPIED  = 6'd8;

  // control register bit positions
  localparam int CTRL_IRQ   = 0;
  localparam int CTRL_FIQ   = 1;
  localparam int CTRL_COPY  = 2;
  localparam int CTRL_RESET = 3;

  // operations of the shared adder
  typedef enum logic [1:0] {
    ALU_INC1 = 2'd0,
    ALU_INC4 = 2'd1,
    ALU_DEC1 = 2'd2
  } alu_op_t;

endpackage

// File: hdl/rdcc_if.sv
// valid/ready channels for requests and results of the copy card
`timescale 1ns / 1ps
interface rdcc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  reg_offset;
  logic [31:0] write_data;
  logic [3:0]  cycle_budget;

  modport source (output valid, func, reg_offset, write_data, cycle_budget, input ready);
  modport sink (input valid, func, reg_offset, write_data, cycle_budget, output ready);
endinterface

interface rdcc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] read_data;
  logic [31:0] move_src;
  logic [31:0] move_dst;
  logic [3:0]  cycles_used;
  logic        irq_line;
  logic        fiq_line;
  logic        last;

  modport source (output valid, kind, read_data, move_src, move_dst, cycles_used,
                  irq_line, fiq_line, last, input ready);
  modport sink (input valid, kind, read_data, move_src, move_dst, cycles_used,
                irq_line, fiq_line, last, output ready);
endinterface

// File: hdl/rdcc_alu.sv
// shared 32-bit increment/decrement unit with zero detect
`timescale 1ns / 1ps
module rdcc_alu
  import rdcc_pkg::*;
(
  input  alu_op_t     op,
  input  logic [31:0] a,
  output logic [31:0] sum,
  output logic        zero
);

  logic [31:0] addend;

  // pick the constant step
  always_comb begin
    case (op)
      ALU_INC1: addend = 32'd1;
      ALU_INC4: addend = 32'd4;
      ALU_DEC1: addend = 32'hFFFF_FFFF;
      default:  addend = 32'd0;
    endcase
  end

  assign sum  = a + addend;
  assign zero = (sum == 32'd0);

endmodule

// File: hdl/register_dma_copy_card_core.sv
// Register dma copy card: register file, copy sequencer and result register.
// Register read or write: captured while idle, result registered in S_EXEC once
// the result slot is free. Run tick: S_RUNCNT, then per word S_LOOP, S_MV_EMIT,
// S_MV_DST, S_MV_LEN, S_MV_CNT (one shared adder steps source, destination,
// length and copied count in turn), then S_FINISH. One request at a time; ready
// only while idle. Reset (rst_n low, sync) clears card state and slot valid.
`timescale 1ns / 1ps
module register_dma_copy_card_core
  import rdcc_pkg::*;
#(
  parameter int WORDS_PER_CYCLE = WPC_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  rdcc_in_if.sink     in_ch,
  rdcc_out_if.source  out_ch
);

  localparam int WCW = (WORDS_PER_CYCLE > 1) ? $clog2(WORDS_PER_CYCLE) : 1;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_EXEC    = 9'b000000010,
    S_RUNCNT  = 9'b000000100,
    S_LOOP    = 9'b000001000,
    S_MV_EMIT = 9'b000010000,
    S_MV_DST  = 9'b000100000,
    S_MV_LEN  = 9'b001000000,
    S_MV_CNT  = 9'b010000000,
    S_FINISH  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // captured request
  logic [1:0]           func_r;
  logic [REG_IDX_W-1:0] idx_r;
  logic [31:0]          data_r;
  logic [3:0]           budget_r;

  // card registers
  logic [2:0]  ctrl_r;
  logic [31:0] src_r, dst_r, len_r, scratch_r, runs_r, copied_r;
  logic        busy_r, done_r;

  // run sequencer
  logic [3:0]     bud_r, used_r;
  logic [WCW-1:0] wcnt_r;
  logic           active_r, len_zero_r;

  // result slot
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [31:0] out_rd_r, out_src_r, out_dst_r;
  logic [3:0]  out_cyc_r;
  logic        out_irq_r, out_fiq_r, out_last_r;

  logic        slot_free;
  logic        emit_res;
  alu_op_t     alu_op;
  logic [31:0] alu_a, alu_sum;
  logic        alu_zero;
  logic [31:0] rd_val;
  logic [2:0]  ctrl_wr;
  logic        wr_reset, word_end;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // a result is loaded into the slot this cycle
  assign emit_res = slot_free &&
                    (((state_r == S_EXEC) && (func_r == FUNC_READ || func_r == FUNC_WRITE)) ||
                     (state_r == S_MV_EMIT) || (state_r == S_FINISH));

  // register read decode
  always_comb begin
    unique case (idx_r)
      REG_ID:      rd_val = CARD_ID;
      REG_CTRL:    rd_val = {29'd0, ctrl_r};
      REG_STATUS:  rd_val = {28'd0, done_r, ctrl_r[CTRL_FIQ], ctrl_r[CTRL_IRQ], busy_r};
      REG_SRC:     rd_val = src_r;
      REG_DST:     rd_val = dst_r;
      REG_LEN:     rd_val = len_r;
      REG_SCRATCH: rd_val = scratch_r;
      REG_RUNS:    rd_val = runs_r;
      REG_COPIED:  rd_val = copied_r;
      default:     rd_val = NONE_DRIVEN;
    endcase
  end

  // control value after a write to CTRL
  assign wr_reset = (idx_r == REG_CTRL) && data_r[CTRL_RESET];
  always_comb begin
    if (idx_r != REG_CTRL) begin
      ctrl_wr = ctrl_r;
    end else if (data_r[CTRL_RESET]) begin
      ctrl_wr = 3'd0;
    end else begin
      ctrl_wr = data_r[2:0];
    end
  end

  // shared adder operand select
  always_comb begin
    case (state_r)
      S_RUNCNT:  begin alu_op = ALU_INC1; alu_a = runs_r;   end
      S_MV_DST:  begin alu_op = ALU_INC4; alu_a = dst_r;    end
      S_MV_LEN:  begin alu_op = ALU_DEC1; alu_a = len_r;    end
      S_MV_CNT:  begin alu_op = ALU_INC1; alu_a = copied_r; end
      default:   begin alu_op = ALU_INC4; alu_a = src_r;    end
    endcase
  end

  rdcc_alu u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .sum  (alu_sum),
    .zero (alu_zero)
  );

  assign word_end = (wcnt_r == WCW'(WORDS_PER_CYCLE - 1)) || len_zero_r;

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = (in_ch.func == FUNC_RUN) ? S_RUNCNT : S_EXEC;
      end
      S_EXEC: begin
        if (func_r != FUNC_READ && func_r != FUNC_WRITE) state_nxt = S_IDLE;
        else if (slot_free) state_nxt = S_IDLE;
      end
      S_RUNCNT:  state_nxt = S_LOOP;
      S_LOOP:    state_nxt = (bud_r != 4'd0 && len_r != 32'd0) ? S_MV_EMIT : S_FINISH;
      S_MV_EMIT: if (slot_free) state_nxt = S_MV_DST;
      S_MV_DST:  state_nxt = S_MV_LEN;
      S_MV_LEN:  state_nxt = S_MV_CNT;
      S_MV_CNT:  state_nxt = S_LOOP;
      S_FINISH:  if (slot_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // state, card registers and result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ctrl_r      <= 3'd0;
      src_r       <= 32'd0;
      dst_r       <= 32'd0;
      len_r       <= 32'd0;
      scratch_r   <= 32'd0;
      runs_r      <= 32'd0;
      copied_r    <= 32'd0;
      busy_r      <= 1'b0;
      done_r      <= 1'b0;
      bud_r       <= 4'd0;
      used_r      <= 4'd0;
      wcnt_r      <= '0;
      active_r    <= 1'b0;
      len_zero_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_res) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      unique case (state_r)
        // capture the request
        S_IDLE: begin
          if (in_ch.valid) begin
            func_r   <= in_ch.func;
            idx_r    <= in_ch.reg_offset[7:2];
            data_r   <= in_ch.write_data;
            budget_r <= in_ch.cycle_budget;
          end
        end
        // register access and its result
        S_EXEC: begin
          if (slot_free && (func_r == FUNC_READ || func_r == FUNC_WRITE)) begin
            out_src_r   <= 32'd0;
            out_dst_r   <= 32'd0;
            out_cyc_r   <= 4'd0;
            out_last_r  <= 1'b1;
            if (func_r == FUNC_READ) begin
              out_kind_r <= KIND_READ;
              out_rd_r   <= rd_val;
              out_irq_r  <= ctrl_r[CTRL_IRQ];
              out_fiq_r  <= ctrl_r[CTRL_FIQ];
            end else begin
              out_kind_r <= KIND_WRITE;
              out_rd_r   <= 32'd0;
              out_irq_r  <= ctrl_wr[CTRL_IRQ];
              out_fiq_r  <= ctrl_wr[CTRL_FIQ];
              if (wr_reset) begin
                ctrl_r    <= 3'd0;
                src_r     <= 32'd0;
                dst_r     <= 32'd0;
                len_r     <= 32'd0;
                scratch_r <= 32'd0;
                runs_r    <= 32'd0;
                copied_r  <= 32'd0;
                busy_r    <= 1'b0;
                done_r    <= 1'b0;
              end else begin
                case (idx_r)
                  REG_CTRL: begin
                    ctrl_r <= ctrl_wr;
                    if (data_r[CTRL_COPY] && len_r != 32'd0) begin
                      busy_r   <= 1'b1;
                      done_r   <= 1'b0;
                      copied_r <= 32'd0;
                    end
                  end
                  REG_SRC:     src_r     <= data_r;
                  REG_DST:     dst_r     <= data_r;
                  REG_LEN:     len_r     <= data_r;
                  REG_SCRATCH: scratch_r <= data_r;
                  default: ;
                endcase
              end
            end
          end
        end
        // count the tick and load the budget
        S_RUNCNT: begin
          runs_r   <= alu_sum;
          active_r <= busy_r && (budget_r != 4'd0);
          bud_r    <= busy_r ? budget_r : 4'd0;
          used_r   <= 4'd0;
          wcnt_r   <= '0;
        end
        S_LOOP: ;
        // emit one word move, step source
        S_MV_EMIT: begin
          if (slot_free) begin
            out_kind_r  <= KIND_MOVE;
            out_rd_r    <= 32'd0;
            out_src_r   <= src_r;
            out_dst_r   <= dst_r;
            out_cyc_r   <= 4'd0;
            out_irq_r   <= ctrl_r[CTRL_IRQ];
            out_fiq_r   <= ctrl_r[CTRL_FIQ];
            out_last_r  <= 1'b0;
            src_r       <= alu_sum;
          end
        end
        S_MV_DST: dst_r <= alu_sum;
        S_MV_LEN: begin
          len_r      <= alu_sum;
          len_zero_r <= alu_zero;
        end
        // count the word, close the bus cycle when full or out of words
        S_MV_CNT: begin
          copied_r <= alu_sum;
          if (word_end) begin
            wcnt_r <= '0;
            bud_r  <= bud_r - 4'd1;
            used_r <= used_r + 4'd1;
          end else begin
            wcnt_r <= wcnt_r + WCW'(1);
          end
        end
        // summary result and copy completion
        S_FINISH: begin
          if (slot_free) begin
            out_kind_r  <= KIND_DONE;
            out_rd_r    <= 32'd0;
            out_src_r   <= 32'd0;
            out_dst_r   <= 32'd0;
            out_cyc_r   <= used_r;
            out_irq_r   <= ctrl_r[CTRL_IRQ];
            out_fiq_r   <= ctrl_r[CTRL_FIQ];
            out_last_r  <= 1'b1;
            if (active_r && len_r == 32'd0) begin
              busy_r            <= 1'b0;
              done_r            <= 1'b1;
              ctrl_r[CTRL_COPY] <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result channel
  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.read_data   = out_rd_r;
  assign out_ch.move_src    = out_src_r;
  assign out_ch.move_dst    = out_dst_r;
  assign out_ch.cycles_used = out_cyc_r;
  assign out_ch.irq_line    = out_irq_r;
  assign out_ch.fiq_line    = out_fiq_r;
  assign out_ch.last        = out_last_r;

endmodule

// File: hdl/rdcc_checker.sv
// port-level checks of the copy card core and their bind
`timescale 1ns / 1ps
module rdcc_checker
  import rdcc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [31:0] out_read_data,
  input logic [31:0] out_move_src,
  input logic [3:0]  out_cycles_used,
  input logic        out_last
);

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_move_src))
    else $error("stalled result changed");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

  // word moves never close a request, every other kind does
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_kind != KIND_MOVE)))
    else $error("last flag does not match result kind");

  // unused fields read as zero
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == KIND_READ) || (out_read_data == 32'd0)) &&
                  ((out_kind == KIND_DONE) || (out_cycles_used == 4'd0)))
    else $error("field outside its result kind not zero");

endmodule

bind register_dma_copy_card_core rdcc_checker u_rdcc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_read_data   (out_ch.read_data),
  .out_move_src    (out_ch.move_src),
  .out_cycles_used (out_ch.cycles_used),
  .out_last        (out_ch.last)
);

// File: dv/register_dma_copy_card_core_tb.sv
// self-checking testbench of the register dma copy card core with a register shadow
`timescale 1ns / 1ps
module register_dma_copy_card_core_tb;
  import rdcc_pkg::*;

  localparam int WORDS_PER_CYCLE = WPC_DEFAULT;
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int DRAIN_CYCLES    = 400;
  localparam int MAX_REPORTS     = 10;
  localparam int PHASE_ITEMS     = 78;

  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam logic [31:0] WORD_BYTES  = 32'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  reg_offset;
    logic [31:0] write_data;
    logic [3:0]  cycle_budget;
  } card_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] read_data;
    logic [31:0] move_src;
    logic [31:0] move_dst;
    logic [3:0]  cycles_used;
    logic        irq_line;
    logic        fiq_line;
    logic        last;
  } card_rsp_t;

  logic clk;
  logic rst_n;

  rdcc_in_if  in_ch ();
  rdcc_out_if out_ch ();

  register_dma_copy_card_core #(
    .WORDS_PER_CYCLE(WORDS_PER_CYCLE)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // request and result bookkeeping
  card_req_t pending_reqs[$];
  card_rsp_t expected_rsps[$];
  card_req_t req_on_bus;
  card_req_t next_req;
  int        queued_cnt     = 0;
  int        stim_cnt       = 0;
  int        accepted_cnt   = 0;
  int        error_cnt      = 0;
  int        cycle_cnt      = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;

  // shadow copy of the card registers
  logic [2:0]  sh_ctrl;
  logic [31:0] sh_src;
  logic [31:0] sh_dst;
  logic [31:0] sh_len;
  logic [31:0] sh_scratch;
  logic [31:0] sh_runs;
  logic [31:0] sh_copied;
  logic        sh_busy;
  logic        sh_done;
  logic        sh_irq;
  logic        sh_fiq;

  function automatic void clear_shadow();
    sh_ctrl    = '0;
    sh_src     = '0;
    sh_dst     = '0;
    sh_len     = '0;
    sh_scratch = '0;
    sh_runs    = '0;
    sh_copied  = '0;
    sh_busy    = 1'b0;
    sh_done    = 1'b0;
    sh_irq     = 1'b0;
    sh_fiq     = 1'b0;
  endfunction

  function automatic logic [31:0] shadow_read(input logic [5:0] idx);
    case (idx)
      REG_ID:      return CARD_ID;
      REG_CTRL:    return {29'd0, sh_ctrl};
      REG_STATUS:  return {28'd0, sh_done, sh_ctrl[CTRL_FIQ], sh_ctrl[CTRL_IRQ], sh_busy};
      REG_SRC:     return sh_src;
      REG_DST:     return sh_dst;
      REG_LEN:     return sh_len;
      REG_SCRATCH: return sh_scratch;
      REG_RUNS:    return sh_runs;
      REG_COPIED:  return sh_copied;
      default:     return NONE_DRIVEN;
    endcase
  endfunction

  function automatic void shadow_write(input logic [5:0] idx, input logic [31:0] data);
    case (idx)
      REG_CTRL: begin
        // reset bit wins over everything else in the write
        if (data[CTRL_RESET]) begin
          clear_shadow();
        end else begin
          sh_ctrl = data[2:0];
          sh_irq  = data[CTRL_IRQ];
          sh_fiq  = data[CTRL_FIQ];
          if (data[CTRL_COPY] && sh_len != 0) begin
            sh_busy   = 1'b1;
            sh_done   = 1'b0;
            sh_copied = '0;
          end
        end
      end
      REG_SRC:     sh_src = data;
      REG_DST:     sh_dst = data;
      REG_LEN:     sh_len = data;
      REG_SCRATCH: sh_scratch = data;
      default: ;
    endcase
  endfunction

  function automatic void push_rsp(input logic [1:0] kind, input logic [31:0] rd,
                                   input logic [31:0] ms, input logic [31:0] md,
                                   input logic [3:0] cyc, input logic last);
    card_rsp_t r;
    r.kind        = kind;
    r.read_data   = rd;
    r.move_src    = ms;
    r.move_dst    = md;
    r.cycles_used = cyc;
    r.irq_line    = sh_irq;
    r.fiq_line    = sh_fiq;
    r.last        = last;
    expected_rsps.push_back(r);
  endfunction

  // expected results of one accepted request
  function automatic void predict_request(input card_req_t r);
    logic [5:0] idx;
    logic [3:0] budget;
    logic [3:0] used;
    idx    = r.reg_offset[7:2];
    budget = r.cycle_budget;
    used   = '0;
    case (r.func)
      FUNC_READ: push_rsp(KIND_READ, shadow_read(idx), '0, '0, '0, 1'b1);
      FUNC_WRITE: begin
        shadow_write(idx, r.write_data);
        push_rsp(KIND_WRITE, '0, '0, '0, '0, 1'b1);
      end
      FUNC_RUN: begin
        sh_runs = sh_runs + 32'd1;
        if (sh_busy && budget != 0) begin
          while (budget != 0 && sh_len != 0) begin
            for (int w = 0; w < WORDS_PER_CYCLE && sh_len != 0; w++) begin
              push_rsp(KIND_MOVE, '0, sh_src, sh_dst, '0, 1'b0);
              sh_src    = sh_src + WORD_BYTES;
              sh_dst    = sh_dst + WORD_BYTES;
              sh_len    = sh_len - 32'd1;
              sh_copied = sh_copied + 32'd1;
            end
            budget = budget - 4'd1;
            used   = used + 4'd1;
          end
          if (sh_len == 0) begin
            sh_busy           = 1'b0;
            sh_done           = 1'b1;
            sh_ctrl[CTRL_COPY] = 1'b0;
          end
        end
        push_rsp(KIND_DONE, '0, '0, '0, used, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // stimulus builders
  task automatic add_req(input logic [1:0] fn, input logic [7:0] off,
                         input logic [31:0] data, input logic [3:0] budget);
    card_req_t r;
    r.func         = fn;
    r.reg_offset   = off;
    r.write_data   = data;
    r.cycle_budget = budget;
    pending_reqs.push_back(r);
    queued_cnt++;
    if (fn != FUNC_UNUSED) stim_cnt++;
  endtask

  task automatic add_read(input logic [5:0] idx);
    add_req(FUNC_READ, {idx, 2'($urandom_range(3))}, $urandom, 4'($urandom_range(15)));
  endtask

  task automatic add_write(input logic [5:0] idx, input logic [31:0] data);
    add_req(FUNC_WRITE, {idx, 2'($urandom_range(3))}, data, 4'($urandom_range(15)));
  endtask

  task automatic add_run(input logic [3:0] budget);
    add_req(FUNC_RUN, 8'($urandom_range(255)), $urandom, budget);
  endtask

  // program addresses and length, start the copy, then tick it along
  task automatic add_copy_sequence();
    int          n_ticks;
    logic [31:0] len_words;
    logic [31:0] ctrl_word;
    case ($urandom_range(9))
      0:       len_words = '0;
      1:       len_words = 32'($urandom_range(41, 120));
      default: len_words = 32'($urandom_range(1, 24));
    endcase
    // sometimes keep the addresses where the last copy left them
    if ($urandom_range(4) != 0)
      add_write(REG_SRC, ($urandom_range(3) == 0) ? 32'hFFFF_FFF0 : $urandom);
    if ($urandom_range(4) != 0) add_write(REG_DST, $urandom);
    add_write(REG_LEN, len_words);
    ctrl_word = $urandom;
    ctrl_word[CTRL_RESET] = 1'b0;
    ctrl_word[CTRL_COPY]  = ($urandom_range(7) != 0);
    add_write(REG_CTRL, ctrl_word);
    n_ticks = $urandom_range(1, 5);
    for (int t = 0; t < n_ticks; t++) begin
      add_run(4'($urandom_range(15)));
      if ($urandom_range(2) == 0) add_read(6'($urandom_range(8)));
    end
    add_read(($urandom_range(1) == 0) ? REG_STATUS : REG_COPIED);
  endtask

  // loose requests: any function, any offset, occasional card reset
  task automatic add_noise();
    int          pick;
    logic [1:0]  fn;
    logic [7:0]  off;
    logic [31:0] data;
    pick = $urandom_range(19);
    if (pick == 0) fn = FUNC_UNUSED;
    else if (pick < 8) fn = FUNC_READ;
    else if (pick < 15) fn = FUNC_WRITE;
    else fn = FUNC_RUN;
    if ($urandom_range(3) == 0) off = 8'($urandom_range(255));
    else off = {6'($urandom_range(8)), 2'($urandom_range(3))};
    data = $urandom;
    if (off[7:2] == REG_CTRL && $urandom_range(3) != 0) data[CTRL_RESET] = 1'b0;
    add_req(fn, off, data, 4'($urandom_range(15)));
  endtask

  task automatic wait_idle();
    while (accepted_cnt < queued_cnt || expected_rsps.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int target;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = stim_cnt + PHASE_ITEMS;
    while (stim_cnt < target) begin
      if ($urandom_range(99) < 70) add_copy_sequence();
      else add_noise();
    end
    wait_idle();
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_request(req_on_bus);
        accepted_cnt++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_reqs.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.func         <= next_req.func;
          in_ch.reg_offset   <= next_req.reg_offset;
          in_ch.write_data   <= next_req.write_data;
          in_ch.cycle_budget <= next_req.cycle_budget;
          req_on_bus         <= next_req;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  task automatic check_result();
    card_rsp_t got;
    card_rsp_t want;
    got.kind        = out_ch.kind;
    got.read_data   = out_ch.read_data;
    got.move_src    = out_ch.move_src;
    got.move_dst    = out_ch.move_dst;
    got.cycles_used = out_ch.cycles_used;
    got.irq_line    = out_ch.irq_line;
    got.fiq_line    = out_ch.fiq_line;
    got.last        = out_ch.last;
    if (expected_rsps.size() == 0) begin
      error_cnt++;
      if (error_cnt <= MAX_REPORTS)
        $display("unexpected result: kind=%0d rdata=%h src=%h dst=%h cyc=%0d",
                 got.kind, got.read_data, got.move_src, got.move_dst, got.cycles_used);
    end else begin
      want = expected_rsps.pop_front();
      if (got.kind !== want.kind || got.read_data !== want.read_data ||
          got.move_src !== want.move_src || got.move_dst !== want.move_dst ||
          got.cycles_used !== want.cycles_used || got.irq_line !== want.irq_line ||
          got.fiq_line !== want.fiq_line || got.last !== want.last) begin
        error_cnt++;
        if (error_cnt <= MAX_REPORTS) begin
          $display("result mismatch: exp kind=%0d rdata=%h src=%h dst=%h cyc=%0d irq=%b fiq=%b last=%b",
                   want.kind, want.read_data, want.move_src, want.move_dst,
                   want.cycles_used, want.irq_line, want.fiq_line, want.last);
          $display("                 got kind=%0d rdata=%h src=%h dst=%h cyc=%0d irq=%b fiq=%b last=%b",
                   got.kind, got.read_data, got.move_src, got.move_dst,
                   got.cycles_used, got.irq_line, got.fiq_line, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_ch.valid && out_ch.ready) check_result();
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // reset, directed requests, then random phases
  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.func          = FUNC_READ;
    in_ch.reg_offset    = '0;
    in_ch.write_data    = '0;
    in_ch.cycle_budget  = '0;
    out_ch.ready        = 1'b0;
    req_on_bus          = '0;
    clear_shadow();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // register file basics: id, status after reset, unknown offset, dropped writes
    add_read(REG_ID);
    add_read(REG_STATUS);
    add_req(FUNC_READ, 8'hFF, 32'h0, 4'h0);
    add_write(REG_ID, 32'hFFFF_FFFF);
    add_req(FUNC_WRITE, {REG_SCRATCH, 2'b11}, 32'hFFFF_FFFF, 4'hF);
    add_read(REG_SCRATCH);
    // copy bit with zero length, then a tick while idle
    add_write(REG_SRC, 32'hFFFF_FFF8);
    add_write(REG_DST, 32'h0000_0000);
    add_write(REG_CTRL, 32'h0000_0005);
    add_run(4'hF);
    // six words across the address wrap, zero budget first
    add_write(REG_LEN, 32'd6);
    add_write(REG_CTRL, 32'h0000_0007);
    add_run(4'h0);
    add_run(4'h1);
    add_run(4'hF);
    add_read(REG_STATUS);
    // busy with length cleared under it finishes at once
    add_write(REG_LEN, 32'd3);
    add_write(REG_CTRL, 32'h0000_0004);
    add_write(REG_LEN, 32'd0);
    add_run(4'h5);
    // unused function code is ignored
    add_req(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF, 4'hF);
    // full-budget tick on a huge length, then card reset
    add_write(REG_LEN, 32'hFFFF_FFFF);
    add_write(REG_CTRL, 32'hFFFF_FFF7);
    add_run(4'hF);
    add_write(REG_CTRL, 32'hFFFF_FFFF);
    add_read(REG_RUNS);
    add_read(REG_CTRL);
    wait_idle();

    run_phase(0, 0);
    run_phase(77, 0);
    run_phase(0, 77);
    run_phase(26, 26);

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_cnt == 0 && expected_rsps.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
